// ===== design/ssml_pkg.sv =====
// shared types and constants for the sorted stream merge list
package ssml_pkg;

   // stream count and key length in characters
   localparam int STREAMS   = 12;
   localparam int KEY_CHARS = 4;

   // port field widths
   localparam int STREAM_W = 4;
   localparam int KEY_W    = 32;

   // width of a list slot address
   localparam int IDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;

   // only the low KEY_CHARS characters of a key are kept
   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_CHARS * 8 >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (KEY_CHARS * 8)) - KEY_W'(1));

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_LISTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_WALK,
      S_LINK,
      S_POP
   } state_type;

   // one request item handed to the list engine
   typedef struct packed {
      op_type                op;
      logic [STREAM_W-1:0]   stream_index;
      logic [KEY_W-1:0]      account_key;
   } cmd_type;

   // one result item from the list engine
   typedef struct packed {
      status_type            status;
      logic [STREAM_W-1:0]   popped_stream;
      logic [KEY_W-1:0]      popped_key;
      logic                  now_empty;
   } res_type;

endpackage

// ===== design/ssml_core.sv =====
// linked list engine: key and link memories, list walk and pop
module ssml_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ssml_pkg::cmd_type cmd,
   output logic              idle,
   output logic              done,
   output ssml_pkg::res_type res
);

   // list memories, one entry per stream
   logic [ssml_pkg::KEY_W-1:0] key_mem_ff  [ssml_pkg::STREAMS];
   ssml_pkg::idx_type          link_mem_ff [ssml_pkg::STREAMS];

   // registered read data
   logic [ssml_pkg::KEY_W-1:0] key_rd_ff;
   ssml_pkg::idx_type          link_rd_ff;

   // memory access controls
   logic                       rd_en;
   ssml_pkg::idx_type          rd_addr;
   logic                       key_we;
   ssml_pkg::idx_type          key_wa;
   logic [ssml_pkg::KEY_W-1:0] key_wd;
   logic                       link_we;
   ssml_pkg::idx_type          link_wa;
   ssml_pkg::idx_type          link_wd;

   // control state
   ssml_pkg::state_type        state_ff, state_in;
   ssml_pkg::idx_type          head_ff, head_in;
   logic                       empty_ff, empty_in;
   logic [ssml_pkg::STREAMS-1:0] in_list_ff, in_list_in;

   // working registers of the item in progress
   ssml_pkg::idx_type          s_ff, s_in;
   logic [ssml_pkg::KEY_W-1:0] key_ff, key_in;
   ssml_pkg::idx_type          cur_ff, cur_in;
   ssml_pkg::idx_type          prev_ff, prev_in;
   ssml_pkg::idx_type          succ_ff, succ_in;

   // decoded request
   logic                       in_range;
   ssml_pkg::idx_type          req_idx;
   logic [ssml_pkg::KEY_W-1:0] req_key;
   logic                       goes_ahead;

   assign in_range = ({1'b0, cmd.stream_index} < (ssml_pkg::STREAM_W + 1)'(ssml_pkg::STREAMS));
   assign req_idx  = cmd.stream_index[ssml_pkg::IDX_W-1:0];
   assign req_key  = cmd.account_key & ssml_pkg::KEY_MASK;

   // new entry sorts ahead of the entry just read, ties to lower stream
   assign goes_ahead = (key_ff < key_rd_ff) || ((key_ff == key_rd_ff) && (s_ff < cur_ff));

   assign idle = (state_ff == ssml_pkg::S_IDLE);

   // memories: one write per store, one shared read address
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[key_wa] <= key_wd;
      end
      if (link_we) begin
         link_mem_ff[link_wa] <= link_wd;
      end
      if (rd_en) begin
         key_rd_ff  <= key_mem_ff[rd_addr];
         link_rd_ff <= link_mem_ff[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssml_pkg::S_IDLE;
         head_ff    <= '0;
         empty_ff   <= 1'b1;
         in_list_ff <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         empty_ff   <= empty_in;
         in_list_ff <= in_list_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      key_ff  <= key_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      succ_ff <= succ_in;
   end

   // sequencer: next state, memory accesses and result
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      empty_in   = empty_ff;
      in_list_in = in_list_ff;
      s_in       = s_ff;
      key_in     = key_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      succ_in    = succ_ff;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      key_we     = 1'b0;
      key_wa     = req_idx;
      key_wd     = req_key;
      link_we    = 1'b0;
      link_wa    = s_ff;
      link_wd    = succ_ff;
      done       = 1'b0;
      res.status        = ssml_pkg::ST_OK;
      res.popped_stream = '0;
      res.popped_key    = '0;
      res.now_empty     = empty_ff;

      case (state_ff)
         ssml_pkg::S_IDLE: begin
            if (start) begin
               if (cmd.op == ssml_pkg::OP_INSERT) begin
                  if (!in_range || in_list_ff[req_idx]) begin
                     // rejected insert leaves the list alone
                     done       = 1'b1;
                     res.status = ssml_pkg::ST_LISTED;
                  end else begin
                     key_we              = 1'b1;
                     in_list_in[req_idx] = 1'b1;
                     s_in                = req_idx;
                     key_in              = req_key;
                     if (empty_ff) begin
                        // first entry becomes head and tail
                        link_we       = 1'b1;
                        link_wa       = req_idx;
                        link_wd       = req_idx;
                        head_in       = req_idx;
                        empty_in      = 1'b0;
                        done          = 1'b1;
                        res.now_empty = 1'b0;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        cur_in   = head_ff;
                        state_in = ssml_pkg::S_HEAD;
                     end
                  end
               end else begin
                  if (empty_ff) begin
                     done          = 1'b1;
                     res.status    = ssml_pkg::ST_EMPTY;
                     res.now_empty = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     cur_in   = head_ff;
                     state_in = ssml_pkg::S_POP;
                  end
               end
            end
         end

         ssml_pkg::S_HEAD, ssml_pkg::S_WALK: begin
            if (goes_ahead) begin
               if (state_ff == ssml_pkg::S_HEAD) begin
                  // new entry takes over the head
                  link_we       = 1'b1;
                  link_wa       = s_ff;
                  link_wd       = cur_ff;
                  head_in       = s_ff;
                  done          = 1'b1;
                  res.now_empty = 1'b0;
                  state_in      = ssml_pkg::S_IDLE;
               end else begin
                  // link in between prev and cur
                  link_we  = 1'b1;
                  link_wa  = prev_ff;
                  link_wd  = s_ff;
                  succ_in  = cur_ff;
                  state_in = ssml_pkg::S_LINK;
               end
            end else begin
               prev_in = cur_ff;
               if (link_rd_ff == cur_ff) begin
                  // reached the tail: append
                  link_we  = 1'b1;
                  link_wa  = cur_ff;
                  link_wd  = s_ff;
                  succ_in  = s_ff;
                  state_in = ssml_pkg::S_LINK;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = link_rd_ff;
                  cur_in   = link_rd_ff;
                  state_in = ssml_pkg::S_WALK;
               end
            end
         end

         ssml_pkg::S_LINK: begin
            // successor of the new entry
            link_we       = 1'b1;
            link_wa       = s_ff;
            link_wd       = succ_ff;
            done          = 1'b1;
            res.now_empty = 1'b0;
            state_in      = ssml_pkg::S_IDLE;
         end

         ssml_pkg::S_POP: begin
            res.popped_stream  = ssml_pkg::STREAM_W'(cur_ff);
            res.popped_key     = key_rd_ff;
            in_list_in[cur_ff] = 1'b0;
            done               = 1'b1;
            if (link_rd_ff == cur_ff) begin
               empty_in      = 1'b1;
               head_in       = '0;
               res.now_empty = 1'b1;
            end else begin
               head_in       = link_rd_ff;
               res.now_empty = 1'b0;
            end
            state_in = ssml_pkg::S_IDLE;
         end

         default: begin
            state_in = ssml_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/sorted_stream_merge_list.sv =====
// Selector for a k-way merge: stream keys kept in a linked list sorted by key, then stream.
// An insert of a stream that is already listed or out of range, a pop of an empty list
// and an insert into an empty list finish straight from idle. A pop reads the head, then
// finishes in the pop state. An insert into a non-empty list reads the head, then either
// becomes the new head or walks the list, linking in between two entries or at the tail
// with a final link state; the walk is set by the single read port of the key and link
// memories, one list entry per cycle. The next item
// is taken as soon as the list engine is idle and the result register is free or being
// emptied in the same cycle.
module sorted_stream_merge_list (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [0:0]                      req_opcode,
   input  logic [ssml_pkg::STREAM_W-1:0]   req_stream_index,
   input  logic [ssml_pkg::KEY_W-1:0]      req_account_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [ssml_pkg::STREAM_W-1:0]   rsp_popped_stream,
   output logic [ssml_pkg::KEY_W-1:0]      rsp_popped_key,
   output logic                            rsp_now_empty
);

   ssml_pkg::cmd_type cmd;
   ssml_pkg::res_type res;
   logic              core_idle;
   logic              core_done;
   logic              out_free;
   logic              start;

   logic              rsp_valid_ff, rsp_valid_in;
   ssml_pkg::res_type rsp_ff, rsp_in;

   // item accepted when the engine is idle and the result slot opens up
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(core_idle && out_free);
   assign start     = req_valid && !req_stall;

   assign cmd.op           = ssml_pkg::op_type'(req_opcode);
   assign cmd.stream_index = req_stream_index;
   assign cmd.account_key  = req_account_key;

   ssml_core u_core (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd),
      .idle  (core_idle),
      .done  (core_done),
      .res   (res)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_popped_stream = rsp_ff.popped_stream;
   assign rsp_popped_key    = rsp_ff.popped_key;
   assign rsp_now_empty     = rsp_ff.now_empty;

endmodule

// ===== bench/sorted_stream_merge_list_test.sv =====
// self-checking bench for the sorted stream merge list: directed and random insert/pop items
module sorted_stream_merge_list_test;
   import ssml_pkg::*;

   localparam int CLOCK_HALF  = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = STREAMS + 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [0:0]            req_opcode = OP_INSERT;
   logic [STREAM_W-1:0]   req_stream_index = '0;
   logic [KEY_W-1:0]      req_account_key = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [STREAM_W-1:0]   rsp_popped_stream;
   logic [KEY_W-1:0]      rsp_popped_key;
   logic                  rsp_now_empty;

   // predicted list state, slot space of the 4-bit stream field
   logic [KEY_W-1:0]      key_mem [16];
   logic [STREAM_W-1:0]   link_mem [16];
   bit                    listed [16];
   logic [STREAM_W-1:0]   head_slot;
   bit                    list_is_empty;

   res_type               pending_results [$];
   int                    fail_count = 0;
   int                    cycle_count = 0;
   int                    stall_left = 0;
   bit                    pace_on = 1'b1;
   int                    placed_count = 0;
   int                    rejected_count = 0;
   int                    pop_count = 0;
   int                    empty_pop_count = 0;

   sorted_stream_merge_list u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_stream_index  (req_stream_index),
      .req_account_key   (req_account_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_stream (rsp_popped_stream),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_now_empty     (rsp_now_empty)
   );

   // clock
   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!pace_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ordering of two list entries: key first, lower stream on a tie
   function automatic bit ahead_of(logic [KEY_W-1:0] ka, int ia, logic [KEY_W-1:0] kb, int ib);
      if (ka != kb) return ka < kb;
      return ia < ib;
   endfunction

   function automatic int list_size();
      int n;
      n = 0;
      for (int i = 0; i < STREAMS; i++) if (listed[i]) n++;
      return n;
   endfunction

   // clear the predicted list
   task automatic clear_list();
      for (int i = 0; i < 16; i++) begin
         key_mem[i] = '0;
         link_mem[i] = '0;
         listed[i] = 1'b0;
      end
      head_slot = '0;
      list_is_empty = 1'b1;
   endtask

   // apply one accepted item to the predicted list and queue its result
   task automatic predict_list_step(op_type op, logic [STREAM_W-1:0] s, logic [KEY_W-1:0] k);
      res_type r;
      logic [KEY_W-1:0] key;
      int prev;
      int cur;
      bit placed;
      r = '0;
      r.status = ST_OK;
      key = k & KEY_MASK;
      if (op == OP_INSERT) begin
         if (s >= STREAMS || listed[s]) begin
            r.status = ST_LISTED;
            rejected_count++;
         end else begin
            placed_count++;
            key_mem[s] = key;
            listed[s] = 1'b1;
            if (list_is_empty) begin
               head_slot = s;
               link_mem[s] = s;
               list_is_empty = 1'b0;
            end else if (ahead_of(key, s, key_mem[head_slot], head_slot)) begin
               link_mem[s] = head_slot;
               head_slot = s;
            end else begin
               // walk to the first entry that sorts after the new one
               prev = head_slot;
               placed = 1'b0;
               for (int n = 0; n < 16 && !placed; n++) begin
                  cur = link_mem[prev];
                  if (cur == prev) begin
                     link_mem[prev] = s;
                     link_mem[s] = s;
                     placed = 1'b1;
                  end else if (ahead_of(key, s, key_mem[cur], cur)) begin
                     link_mem[prev] = s;
                     link_mem[s] = cur;
                     placed = 1'b1;
                  end else begin
                     prev = cur;
                  end
               end
               if (!placed) begin
                  link_mem[prev] = s;
                  link_mem[s] = s;
               end
            end
         end
      end else if (list_is_empty) begin
         r.status = ST_EMPTY;
         empty_pop_count++;
      end else begin
         // unlink the head
         pop_count++;
         r.popped_stream = head_slot;
         r.popped_key = key_mem[head_slot];
         listed[head_slot] = 1'b0;
         if (link_mem[head_slot] == head_slot) begin
            list_is_empty = 1'b1;
            head_slot = '0;
         end else begin
            head_slot = link_mem[head_slot];
         end
      end
      r.now_empty = list_is_empty;
      pending_results.push_back(r);
   endtask

   // send one item and wait for it to be taken; valid stays up for a back-to-back item
   task automatic send_item(op_type op, logic [STREAM_W-1:0] s, logic [KEY_W-1:0] k);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_stream_index <= s;
      req_account_key <= k;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_list_step(op, s, k);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (pace_on && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 30);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected: status %0d stream %0d key %h",
                   rsp_status, rsp_popped_stream, rsp_popped_key);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_popped_stream !== want.popped_stream) begin
               $error("popped_stream: expected %0d, got %0d",
                      want.popped_stream, rsp_popped_stream);
               fail_count++;
            end
            if (rsp_popped_key !== want.popped_key) begin
               $error("popped_key: expected %h, got %h", want.popped_key, rsp_popped_key);
               fail_count++;
            end
            if (rsp_now_empty !== want.now_empty) begin
               $error("now_empty: expected %0d, got %0d", want.now_empty, rsp_now_empty);
               fail_count++;
            end
         end
      end
   end

   // pops on a freshly reset list, with junk in the ignored fields
   task automatic test_pop_empty();
      send_item(OP_POP, 4'hF, 32'hFFFF_FFFF);
      send_item(OP_POP, 4'h0, 32'h0000_0000);
   endtask

   // first insert, new head, tail append, middle and tie placement
   task automatic test_order_and_ties();
      send_item(OP_INSERT, 4'd4, 32'h8000_0000);
      send_item(OP_INSERT, 4'd9, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 4'd0, 32'h0000_0000);
      send_item(OP_INSERT, 4'd2, 32'h0000_0000);
      send_item(OP_INSERT, 4'd11, 32'h8000_0000);
      send_item(OP_INSERT, 4'd7, 32'h8000_0000);
      send_item(OP_INSERT, 4'd1, 32'h7FFF_FFFF);
   endtask

   // already listed streams and indexes past the last stream
   task automatic test_rejects();
      send_item(OP_INSERT, 4'd2, 32'h1234_5678);
      send_item(OP_INSERT, 4'd9, 32'h0000_0000);
      send_item(OP_INSERT, 4'd12, 32'h0000_0001);
      send_item(OP_INSERT, 4'd15, 32'hFFFF_FFFF);
   endtask

   // pop everything, then once more on the empty list
   task automatic test_drain();
      while (list_size() > 0) send_item(OP_POP, 4'($urandom_range(0, 15)), $urandom());
      send_item(OP_POP, 4'd5, 32'h5555_AAAA);
   endtask

   // keys biased toward extremes and ties, full random otherwise
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return {8'h41 + 8'($urandom_range(0, 2)), 24'h20_2020};
      return $urandom();
   endfunction

   // fill and drain runs toward random list sizes, with some noise items
   task automatic test_random_merge();
      int target;
      int free_slots [$];
      int pick;
      target = $urandom_range(0, STREAMS);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a quiet stretch with no gaps or stalls now and then
         if (n % 50 == 0) pace_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            send_item(op_type'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom());
         end else if (list_size() < target) begin
            free_slots.delete();
            for (int i = 0; i < STREAMS; i++) if (!listed[i]) free_slots.push_back(i);
            pick = free_slots[$urandom_range(0, free_slots.size() - 1)];
            send_item(OP_INSERT, 4'(pick), pick_key());
         end else begin
            send_item(OP_POP, 4'($urandom_range(0, 15)), $urandom());
            if (list_size() <= target) target = $urandom_range(0, STREAMS);
         end
         if (list_size() == target && $urandom_range(0, 1) == 0)
            target = $urandom_range(0, STREAMS);
      end
      pace_on = 1'b1;
      test_drain();
   endtask

   // test sequence
   initial begin
      clear_list();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_pop_empty();
      test_order_and_ties();
      test_rejects();
      test_drain();
      test_random_merge();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d placed inserts, %0d rejected inserts, %0d pops, %0d empty pops",
               placed_count, rejected_count, pop_count, empty_pop_count);
      $display("with ties, extreme keys, out-of-range streams and random gaps on both sides");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
